FILE: src/bencode_dict_span_splitter_defines.svh
// Assertion macros shared by the splitter modules.
// Each macro expects aclk and aresetn to be visible in the calling module.
`ifndef BENCODE_DICT_SPAN_SPLITTER_DEFINES_SVH
`define BENCODE_DICT_SPAN_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BDS_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BDS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/bds_pkg.sv
package bds_pkg;

    // Default widths of the offset counters and the nesting depth
    localparam int OFFSET_BITS_DEF = 24;
    localparam int DEPTH_BITS_DEF  = 8;

    // Width of the span offsets on the result port
    localparam int SPAN_W = 24;

    // Token characters
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_FIRST   = 3'd0,
        MODE_SINGLE  = 3'd1,
        MODE_BETWEEN = 3'd2,
        MODE_DICT    = 3'd3,
        MODE_INT     = 3'd4,
        MODE_LEN     = 3'd5,
        MODE_SKIP    = 3'd6,
        MODE_STOP    = 3'd7
    } mode_t;

    // One input byte request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One result request
    typedef struct packed {
        logic              span_valid;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              end_of_stream;
    } result_t;

endpackage

FILE: src/bds_in_reg.sv
module bds_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte
    input  logic              take,
    output logic              item_valid,
    output bds_pkg::item_t    item
);

    logic           valid_reg;
    logic           valid_next;
    bds_pkg::item_t item_reg;

    // Accept a new request when empty or when the held one moves on this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/bds_scan_core.sv
`include "bencode_dict_span_splitter_defines.svh"

module bds_scan_core #(
    parameter int OFFSET_BITS = bds_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = bds_pkg::DEPTH_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  bds_pkg::item_t   item,
    output logic             res_hit,
    output bds_pkg::result_t res
);

    localparam int LEN_W  = OFFSET_BITS + 4;
    localparam int WIDE_W = OFFSET_BITS + bds_pkg::SPAN_W;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX   = {OFFSET_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};

    bds_pkg::mode_t         mode_reg,   mode_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg,  start_next;
    logic [DEPTH_BITS-1:0]  depth_reg,  depth_next;
    logic [OFFSET_BITS-1:0] len_reg,    len_next;
    logic [OFFSET_BITS-1:0] skip_reg,   skip_next;

    logic [7:0]             c;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LEN_W-1:0]       len_prod;
    logic [OFFSET_BITS-1:0] len_sat;
    logic [OFFSET_BITS-1:0] offset_inc;
    logic                   tok;
    logic                   done;
    logic                   single_done;
    logic [OFFSET_BITS-1:0] span_start_w;
    logic [OFFSET_BITS-1:0] span_end_w;
    logic [WIDE_W-1:0]      start_wide;
    logic [WIDE_W-1:0]      end_wide;

    assign c        = item.data_byte;
    assign is_digit = c inside {[bds_pkg::CH_0:bds_pkg::CH_9]};
    assign digit    = c[3:0];

    // Decimal length step: len * 10 + digit, saturated
    assign len_prod = (LEN_W'(len_reg) << 3) + (LEN_W'(len_reg) << 1) + LEN_W'(digit);
    assign len_sat  = (len_prod > LEN_W'(OFF_MAX)) ? OFF_MAX : len_prod[OFFSET_BITS-1:0];

    assign offset_inc = (offset_reg == OFF_MAX) ? OFF_MAX : offset_reg + 1'b1;

    // Next state for the held byte
    always_comb begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        depth_next  = depth_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        tok         = 1'b0;
        done        = 1'b0;

        case (mode_reg)
            bds_pkg::MODE_FIRST: begin
                if (c == bds_pkg::CH_D) begin
                    mode_next = bds_pkg::MODE_SINGLE;
                end else if (c == bds_pkg::CH_L) begin
                    mode_next = bds_pkg::MODE_BETWEEN;
                end else begin
                    mode_next = bds_pkg::MODE_STOP;
                end
            end
            bds_pkg::MODE_BETWEEN: begin
                if (c == bds_pkg::CH_D) begin
                    start_next = offset_reg;
                    depth_next = DEPTH_BITS'(1);
                    mode_next  = bds_pkg::MODE_DICT;
                end else begin
                    mode_next = bds_pkg::MODE_STOP;
                end
            end
            bds_pkg::MODE_DICT: begin
                tok = 1'b1;
            end
            bds_pkg::MODE_INT: begin
                if (c == bds_pkg::CH_E) begin
                    mode_next = bds_pkg::MODE_DICT;
                end
            end
            bds_pkg::MODE_LEN: begin
                if (is_digit) begin
                    len_next = len_sat;
                end else if (c == bds_pkg::CH_COLON) begin
                    skip_next = len_reg;
                    mode_next = (len_reg != '0) ? bds_pkg::MODE_SKIP : bds_pkg::MODE_DICT;
                end else if (len_reg == '0) begin
                    // missing colon after a zero length: scan byte as a token
                    tok = 1'b1;
                end else begin
                    // missing colon: byte is the first string byte
                    skip_next = len_reg - 1'b1;
                    mode_next = (len_reg != OFFSET_BITS'(1)) ? bds_pkg::MODE_SKIP
                                                             : bds_pkg::MODE_DICT;
                end
            end
            bds_pkg::MODE_SKIP: begin
                if (skip_reg > OFFSET_BITS'(1)) begin
                    skip_next = skip_reg - 1'b1;
                end else begin
                    skip_next = '0;
                    mode_next = bds_pkg::MODE_DICT;
                end
            end
            default: begin
                // single record and stopped: ignore bytes
            end
        endcase

        // Dictionary token
        if (tok) begin
            mode_next = bds_pkg::MODE_DICT;
            if (c == bds_pkg::CH_D || c == bds_pkg::CH_L) begin
                if (depth_reg == DEPTH_MAX) begin
                    mode_next = bds_pkg::MODE_STOP;
                end else begin
                    depth_next = depth_reg + 1'b1;
                end
            end else if (c == bds_pkg::CH_E) begin
                if (depth_reg <= DEPTH_BITS'(1)) begin
                    depth_next = '0;
                    mode_next  = bds_pkg::MODE_BETWEEN;
                    done       = 1'b1;
                end else begin
                    depth_next = depth_reg - 1'b1;
                end
            end else if (c == bds_pkg::CH_I) begin
                mode_next = bds_pkg::MODE_INT;
            end else if (is_digit) begin
                len_next  = OFFSET_BITS'(digit);
                mode_next = bds_pkg::MODE_LEN;
            end else begin
                mode_next = bds_pkg::MODE_STOP;
            end
        end

        // Advance offset, or return to reset state at end of stream
        if (item.last_byte) begin
            mode_next   = bds_pkg::MODE_FIRST;
            offset_next = '0;
            start_next  = '0;
            depth_next  = '0;
            len_next    = '0;
            skip_next   = '0;
        end else begin
            offset_next = offset_inc;
        end
    end

    // Span of a single-record stream closes at its final byte, which may be
    // the opening 'd' itself
    assign single_done = !done && item.last_byte &&
                         ((mode_reg == bds_pkg::MODE_SINGLE) ||
                          ((mode_reg == bds_pkg::MODE_FIRST) && (c == bds_pkg::CH_D)));

    assign span_start_w = done ? start_reg : '0;
    assign span_end_w   = (done || single_done) ? offset_inc : '0;
    assign start_wide   = WIDE_W'(span_start_w);
    assign end_wide     = WIDE_W'(span_end_w);

    assign res_hit           = done || item.last_byte;
    assign res.span_valid    = done || single_done;
    assign res.span_start    = start_wide[bds_pkg::SPAN_W-1:0];
    assign res.span_end      = end_wide[bds_pkg::SPAN_W-1:0];
    assign res.end_of_stream = item.last_byte;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= bds_pkg::MODE_FIRST;
            offset_reg <= '0;
            start_reg  <= '0;
            depth_reg  <= '0;
            len_reg    <= '0;
            skip_reg   <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            depth_reg  <= depth_next;
            len_reg    <= len_next;
            skip_reg   <= skip_next;
        end
    end

    `BDS_ASSERT_IMPL(a_hit_mid_stream_is_span, res_hit && !item.last_byte, res.span_valid, "result before end of stream without a span")
    `BDS_ASSERT_IMPL(a_no_span_zero_offsets, !res.span_valid, (res.span_start == '0) && (res.span_end == '0), "offsets nonzero without a span")
    `BDS_ASSERT_NEXT(a_last_returns_first, fire && item.last_byte, (mode_reg == bds_pkg::MODE_FIRST) && (offset_reg == '0), "state not cleared after final byte")
    `BDS_ASSERT_IMPL(a_between_depth_zero, mode_reg == bds_pkg::MODE_BETWEEN, depth_reg == '0, "depth nonzero between dictionaries")

endmodule

FILE: src/bds_out_reg.sv
`include "bencode_dict_span_splitter_defines.svh"

module bds_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bds_pkg::result_t res,
    output logic             slot_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // [23:0] span_start, [47:24] span_end
    output logic             m_tuser,   // span_valid
    output logic             m_tlast    // end_of_stream
);

    logic             valid_reg;
    logic             valid_next;
    bds_pkg::result_t res_reg;

    // Slot frees when empty or when the held request is taken this cycle
    assign slot_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (slot_ready) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (load && slot_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.span_end, res_reg.span_start};
    assign m_tuser  = res_reg.span_valid;
    assign m_tlast  = res_reg.end_of_stream;

    `BDS_ASSERT_IMPL(a_load_only_when_free, load, slot_ready, "result loaded into a full slot")
    `BDS_ASSERT_NEXT(a_stalled_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

FILE: src/bencode_dict_span_splitter.sv
// Bencode dictionary span splitter: takes a bencoded stream one byte per
// request on the s_ side (tlast marks the final byte) and reports dictionary
// spans on the m_ side. A stream opening with 'd' is one record, reported on
// its final byte as 0 to offset+1; a stream opening with 'l' yields one span
// per top-level dictionary on the byte that closes it, with integers and
// length-prefixed strings skipped. Scanning halts until end of stream on a
// stray byte, on a non-'d' between dictionaries, or on depth overflow. Every
// final byte yields a result (tlast high) even when no span closes there;
// m_tuser is low for a result that carries no span, and then both offsets are
// zero. The block takes one byte per cycle; a byte is held in the input
// register, the scanner state is updated from it as it moves on, and its
// result is captured in the result register, which drives m_tvalid. The rate
// is set by the update of the scanner state between the two registers, and it
// drops only while a result waits on m_tready. No clearing pass follows reset.
module bencode_dict_span_splitter #(
    parameter int OFFSET_BITS = bds_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = bds_pkg::DEPTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [23:0] span_start, [47:24] span_end
    output logic        m_tuser,    // span_valid
    output logic        m_tlast     // end_of_stream
);

    logic             item_valid;
    bds_pkg::item_t   item;
    logic             res_hit;
    bds_pkg::result_t res;
    logic             slot_ready;
    logic             fire;

    // Process the held byte when its result, if any, has a free slot
    assign fire = item_valid && (!res_hit || slot_ready);

    bds_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    bds_scan_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_scan_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res_hit (res_hit),
        .res     (res)
    );

    bds_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire && res_hit),
        .res        (res),
        .slot_ready (slot_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
